@@ rtl/mi3_pkg.sv @@
// Shared types, widths and helper functions for the 3x3 matrix inverse block.
// Used by every module and interface under rtl/ except mi3_checker.
package mi3_pkg;

  localparam int ELEM_W        = 32;   // element width, signed fixed point
  localparam int NL            = 9;    // elements per matrix
  localparam int QW            = 32;   // quotient bits produced by the divider
  localparam int PROD_W        = 64;   // element by element product
  localparam int CW            = 65;   // signed cofactor
  localparam int MAGW          = 64;   // cofactor magnitude
  localparam int TERM_W        = 97;   // element by cofactor product
  localparam int DETW          = 99;   // signed determinant
  localparam int DMW           = 98;   // determinant magnitude
  localparam int DENW          = DMW + 1;
  localparam int EPS_W         = 31;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  typedef logic signed [ELEM_W-1:0] elem_t;

  // Per-matrix control that travels from the front end into the divider.
  typedef struct packed {
    logic            singular;
    logic [DENW-1:0] den;
  } mi3_ctl_t;

  // One divider lane result: raw quotient, quotient overflow and result sign.
  typedef struct packed {
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } mi3_quo_t;

  // Rows (or columns) that remain when row (or column) i is struck out.
  function automatic int minor_lo(int i);
    return (i == 0) ? 1 : 0;
  endfunction

  function automatic int minor_hi(int i);
    return (i == 2) ? 1 : 2;
  endfunction

  // Remainder width: holds the scaled numerator and the divisor shifted by QW.
  function automatic int rem_w(int frac);
    int numw;
    int denq;
    numw = MAGW + 2 * frac + 2;
    denq = DENW + QW;
    return ((numw > denq) ? numw : denq) + 1;
  endfunction

endpackage

@@ rtl/mi3_ifs.sv @@
// Valid/ready stream interfaces for the matrix input and the inverse output.
// Depends on mi3_pkg for the element type.
interface mi3_mat_if import mi3_pkg::*;;
  logic  valid;
  logic  ready;
  elem_t in_r0c0, in_r0c1, in_r0c2;
  elem_t in_r1c0, in_r1c1, in_r1c2;
  elem_t in_r2c0, in_r2c1, in_r2c2;

  modport source(output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                 in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink(input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface mi3_inv_if import mi3_pkg::*;;
  logic  valid;
  logic  ready;
  elem_t inv_r0c0, inv_r0c1, inv_r0c2;
  elem_t inv_r1c0, inv_r1c1, inv_r1c2;
  elem_t inv_r2c0, inv_r2c1, inv_r2c2;
  logic  singular;
  logic  saturated;

  modport source(output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
                 inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated, input ready);
  modport sink(input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated, output ready);
endinterface

@@ rtl/mi3_front.sv @@
// Front end: minors, cofactors, determinant, singular test and divider operands.
// Seven register stages; depends on mi3_pkg.
module mi3_front import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int RW = rem_w(FRAC_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  elem_t            elem [NL],
  input  logic [EPS_W-1:0] eps,
  output logic             out_valid,
  input  logic             out_ready,
  output mi3_ctl_t         ctl,
  output logic [RW-1:0]    num [NL],
  output logic [NL-1:0]    neg
);

  localparam int NS = 7;

  logic [NS-1:0] v;
  logic [NS:0]   adv;

  logic signed [PROD_W-1:0] p1_r [NL];
  logic signed [PROD_W-1:0] p2_r [NL];
  elem_t                    a1 [3];
  elem_t                    a2 [3];
  logic signed [CW-1:0]     cof2 [NL];
  logic signed [CW-1:0]     cof3 [NL];
  logic signed [CW-1:0]     cof4 [NL];
  logic signed [CW-1:0]     cof5 [NL];
  logic signed [CW-1:0]     pph3 [3];
  logic signed [CW-1:0]     ppl3 [3];
  logic signed [TERM_W-1:0] term4 [3];
  logic signed [DETW-1:0]   det5;
  logic [DMW-1:0]           dmag6;
  logic                     dneg6;
  logic [MAGW-1:0]          adjmag6 [NL];
  logic [NL-1:0]            cneg6;
  logic [DMW-1:0]           thr;

  // A stage takes a new transaction when it is empty or its content moves on.
  always_comb begin
    adv[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !v[s] || adv[s+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) v[s] <= v[s-1];
      end
    end
  end

  for (genvar c = 0; c < NL; c++) begin : g_cof
    localparam int RA  = minor_lo(c / 3);
    localparam int RB  = minor_hi(c / 3);
    localparam int CA  = minor_lo(c % 3);
    localparam int CB  = minor_hi(c % 3);
    localparam bit ODD = ((c / 3 + c % 3) % 2) == 1;
    // The adjugate is the transposed cofactor matrix.
    localparam int SRC = (c % 3) * 3 + c / 3;

    always_ff @(posedge clk) begin
      if (adv[0]) begin
        p1_r[c] <= elem[RA*3+CA] * elem[RB*3+CB];
        p2_r[c] <= elem[RB*3+CA] * elem[RA*3+CB];
      end
      if (adv[1]) begin
        cof2[c] <= ODD ? (CW'(p2_r[c]) - CW'(p1_r[c])) : (CW'(p1_r[c]) - CW'(p2_r[c]));
      end
      if (adv[2]) cof3[c] <= cof2[c];
      if (adv[3]) cof4[c] <= cof3[c];
      if (adv[4]) cof5[c] <= cof4[c];
      if (adv[5]) begin
        adjmag6[c] <= cof5[SRC][CW-1] ? MAGW'(-cof5[SRC]) : MAGW'(cof5[SRC]);
        cneg6[c]   <= cof5[SRC][CW-1];
      end
      if (adv[6]) begin
        num[c] <= (RW'(adjmag6[c]) << (2 * FRAC_BITS + 1)) + RW'(dmag6);
      end
    end
  end

  // Row 0 expansion; the 65-bit cofactor is split into a signed 33-bit upper part and an unsigned 32-bit lower part.
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (adv[0]) a1[j] <= elem[j];
      if (adv[1]) a2[j] <= a1[j];
      if (adv[2]) begin
        pph3[j] <= a2[j] * $signed(cof2[j][CW-1:32]);
        ppl3[j] <= a2[j] * $signed({1'b0, cof2[j][31:0]});
      end
      if (adv[3]) term4[j] <= (TERM_W'(pph3[j]) <<< 32) + TERM_W'(ppl3[j]);
    end
  end

  assign thr = DMW'(eps) << (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (adv[4]) det5 <= DETW'(term4[0]) + DETW'(term4[1]) + DETW'(term4[2]);
    if (adv[5]) begin
      dneg6 <= det5[DETW-1];
      dmag6 <= det5[DETW-1] ? DMW'(-det5) : DMW'(det5);
    end
    if (adv[6]) begin
      ctl.singular <= (dmag6 <= thr);
      ctl.den      <= {dmag6, 1'b0};
      neg          <= cneg6 ^ {NL{dneg6}};
    end
  end

endmodule

@@ rtl/mi3_div.sv @@
// Pipelined restoring divider: nine lanes sharing one divisor, one quotient
// bit per stage after an overflow check. Depends on mi3_pkg.
module mi3_div import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int RW = rem_w(FRAC_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mi3_ctl_t      ctl,
  input  logic [RW-1:0] num [NL],
  input  logic [NL-1:0] neg,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_singular,
  output mi3_quo_t      quo [NL]
);

  localparam int NS = QW + 1;

  logic [NS-1:0]   v;
  logic [NS:0]     adv;
  logic [RW-1:0]   rem [QW][NL];
  logic [QW-1:0]   qb [NS][NL];
  logic [NL-1:0]   ovf [NS];
  logic [NL-1:0]   ngs [NS];
  logic [DENW-1:0] den [QW];
  logic [NS-1:0]   sing;

  always_comb begin
    adv[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !v[s] || adv[s+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) v[s] <= v[s-1];
      end
    end
  end

  // Stage 0: a quotient of 2^QW or more can only saturate.
  for (genvar l = 0; l < NL; l++) begin : g_first
    always_ff @(posedge clk) begin
      if (adv[0]) begin
        rem[0][l] <= num[l];
        qb[0][l]  <= '0;
        ovf[0][l] <= num[l] >= (RW'(ctl.den) << QW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ngs[0]  <= neg;
      den[0]  <= ctl.den;
      sing[0] <= ctl.singular;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    localparam int K = QW - s;

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [RW-1:0] shifted;
      logic [RW:0]   diff;

      assign shifted = RW'(den[s-1]) << K;
      assign diff    = {1'b0, rem[s-1][l]} - {1'b0, shifted};

      always_ff @(posedge clk) begin
        if (adv[s]) begin
          qb[s][l]  <= qb[s-1][l] | (QW'(!diff[RW]) << K);
          ovf[s][l] <= ovf[s-1][l];
        end
      end

      if (s < QW) begin : g_rem
        always_ff @(posedge clk) begin
          if (adv[s]) rem[s][l] <= diff[RW] ? rem[s-1][l] : diff[RW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        ngs[s]  <= ngs[s-1];
        sing[s] <= sing[s-1];
      end
    end

    if (s < QW) begin : g_den
      always_ff @(posedge clk) begin
        if (adv[s]) den[s] <= den[s-1];
      end
    end
  end

  assign out_singular = sing[NS-1];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      quo[l].q   = qb[NS-1][l];
      quo[l].ovf = ovf[NS-1][l];
      quo[l].neg = ngs[NS-1][l];
    end
  end

endmodule

@@ rtl/mi3_out.sv @@
// Output stage: saturation, sign, singular zeroing and the output register.
// Depends on mi3_pkg and mi3_inv_if.
module mi3_out import mi3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      singular,
  input  mi3_quo_t  quo [NL],
  mi3_inv_if.source inverse
);

  localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

  logic          ov;
  logic [QW-1:0] res [NL];
  logic [QW-1:0] res_next [NL];
  logic [NL-1:0] clip;
  logic          sing_r;
  logic          sat_r;

  assign in_ready = !ov || inverse.ready;

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] val;
    lim = '0;
    val = '0;
    for (int l = 0; l < NL; l++) begin
      lim     = quo[l].neg ? LIM_NEG : LIM_POS;
      clip[l] = quo[l].ovf || (quo[l].q > lim);
      val     = clip[l] ? lim : quo[l].q;
      res_next[l] = singular ? '0 : (quo[l].neg ? -val : val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (in_ready) begin
      ov <= in_valid;
    end
    if (in_ready) begin
      res    <= res_next;
      sing_r <= singular;
      sat_r  <= !singular && (|clip);
    end
  end

  assign inverse.valid     = ov;
  assign inverse.inv_r0c0  = res[0];
  assign inverse.inv_r0c1  = res[1];
  assign inverse.inv_r0c2  = res[2];
  assign inverse.inv_r1c0  = res[3];
  assign inverse.inv_r1c1  = res[4];
  assign inverse.inv_r1c2  = res[5];
  assign inverse.inv_r2c0  = res[6];
  assign inverse.inv_r2c1  = res[7];
  assign inverse.inv_r2c2  = res[8];
  assign inverse.singular  = sing_r;
  assign inverse.saturated = sat_r;

endmodule

@@ rtl/matrix3_inverse_unit.sv @@
// 3x3 fixed-point matrix inverse by the adjugate, fully pipelined.
// Usage:
//   matrix  (sink):   one 3x3 matrix per transaction, nine signed elements in
//                     row-major order with FRAC_BITS fraction bits.
//   inverse (source): the nine inverse elements in the same format, plus the
//                     singular flag (outputs zero) and the saturated flag.
//   cfg_wr_en/cfg_wr_data: write singular_epsilon; change it only when idle.
// Pipeline: between an accepted matrix and its valid result lie 7 front-end
// stages (products, cofactors, determinant, singular test), 33 divider stages
// (overflow check then one quotient bit per stage) and the output register.
// Throughput: one matrix per cycle unless stalled; the 32-bit restoring
// divider has one stage per quotient bit and nine lanes sharing the divisor.
// Stalls: a full stage holds while the next one cannot take it, so a stalled
// receiver backs the pipeline up stage by stage; empty stages keep filling
// and the matrix channel stays ready until every stage holds a transaction.
// Reset: clears all stage valid bits and sets singular_epsilon to 1.
module matrix3_inverse_unit import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [EPS_W-1:0] cfg_wr_data,
  mi3_mat_if.sink          matrix,
  mi3_inv_if.source        inverse
);

  localparam int RW = rem_w(FRAC_BITS);

  logic [EPS_W-1:0] eps;
  elem_t            elem [NL];
  logic             f_valid;
  logic             f_ready;
  mi3_ctl_t         f_ctl;
  logic [RW-1:0]    f_num [NL];
  logic [NL-1:0]    f_neg;
  logic             d_valid;
  logic             d_ready;
  logic             d_singular;
  mi3_quo_t         d_quo [NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_wr_en) begin
      eps <= cfg_wr_data;
    end
  end

  assign elem[0] = matrix.in_r0c0;
  assign elem[1] = matrix.in_r0c1;
  assign elem[2] = matrix.in_r0c2;
  assign elem[3] = matrix.in_r1c0;
  assign elem[4] = matrix.in_r1c1;
  assign elem[5] = matrix.in_r1c2;
  assign elem[6] = matrix.in_r2c0;
  assign elem[7] = matrix.in_r2c1;
  assign elem[8] = matrix.in_r2c2;

  mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (matrix.valid),
    .in_ready  (matrix.ready),
    .elem      (elem),
    .eps       (eps),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .ctl       (f_ctl),
    .num       (f_num),
    .neg       (f_neg)
  );

  mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (f_valid),
    .in_ready     (f_ready),
    .ctl          (f_ctl),
    .num          (f_num),
    .neg          (f_neg),
    .out_valid    (d_valid),
    .out_ready    (d_ready),
    .out_singular (d_singular),
    .quo          (d_quo)
  );

  mi3_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .singular (d_singular),
    .quo      (d_quo),
    .inverse  (inverse)
  );

endmodule

@@ rtl/mi3_checker.sv @@
// Port-level assertions for matrix3_inverse_unit, attached by the bind below.
// Sees only the top-level ports.
module mi3_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        singular,
  input logic        saturated,
  input logic [31:0] r0c0,
  input logic [31:0] r1c1,
  input logic [31:0] r2c2
);

  // A result transaction that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("inverse valid dropped while stalled");

  // A singular matrix never reports saturation.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(singular && saturated))
    else $error("singular and saturated both set");

  // A singular matrix produces zeros; the diagonal elements are checked.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> r0c0 == 32'd0 && r1c1 == 32'd0 && r2c2 == 32'd0)
    else $error("singular result is not zero");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind matrix3_inverse_unit mi3_checker u_mi3_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (inverse.valid),
  .out_ready (inverse.ready),
  .singular  (inverse.singular),
  .saturated (inverse.saturated),
  .r0c0      (inverse.inv_r0c0),
  .r1c1      (inverse.inv_r1c1),
  .r2c2      (inverse.inv_r2c2)
);
